@@ rtl/wgm_pkg.sv @@
// shared types and constants for the wildcard glob matcher
package wgm_pkg;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_TEXT   = 2'd2,
    OP_END    = 2'd3
  } opcode_t;

  localparam logic [7:0] STAR_CHAR  = 8'd42;
  localparam logic [7:0] QUERY_CHAR = 8'd63;

  // what one pattern cell reports to the chain
  typedef struct packed {
    logic star;   // cell in use and holds a star
    logic stay;   // active star keeps its own position
    logic adv;    // active cell consumed the text byte, next position gets it
  } cell_out_t;

endpackage

@@ rtl/wgm_cell.sv @@
// one pattern position: stored byte, in-use bit and per-byte step logic
module wgm_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                clear,
  input  logic                load,
  input  logic [7:0]          load_char,
  input  logic                active,
  input  logic [7:0]          text_char,
  output wgm_pkg::cell_out_t  cell_out
);

  logic [7:0] char_r;
  logic       used_r;
  logic       used_nxt;
  logic       is_star;
  logic       hit;

  always_ff @(posedge clk) begin
    if (load) begin
      char_r <= load_char;
    end
  end

  always_comb begin
    used_nxt = used_r;
    if (clear) begin
      used_nxt = 1'b0;
    end else if (load) begin
      used_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= 1'b0;
    end else begin
      used_r <= used_nxt;
    end
  end

  assign is_star = used_r && (char_r == wgm_pkg::STAR_CHAR);
  assign hit     = (char_r == wgm_pkg::QUERY_CHAR) || (char_r == text_char);

  assign cell_out.star = is_star;
  assign cell_out.stay = active && is_star;
  assign cell_out.adv  = active && used_r && !is_star && hit;

endmodule

@@ rtl/wgm_closure.sv @@
// star closure: spreads each active position forward through runs of stars
module wgm_closure #(
  parameter int WIDTH = 65
) (
  input  logic [WIDTH-1:0] seeds,
  input  logic [WIDTH-1:0] prop,
  output logic [WIDTH-1:0] closed
);

  logic [WIDTH-1:0] entry;
  logic [WIDTH-1:0] sum;
  logic [WIDTH-1:0] reached;

  // a seed entering a run of propagate bits ripples as a carry to its end
  assign entry   = {seeds[WIDTH-2:0], 1'b0} & prop;
  assign sum     = prop + entry;
  assign reached = (prop & ~sum) | entry;
  assign closed  = seeds | reached;

endmodule

@@ rtl/wildcard_glob_matcher_unit.sv @@
// top level of the streaming wildcard glob matcher
//
//  channel | ports                                   | dir
//  --------+-----------------------------------------+-----
//  in      | in_valid in_stall in_opcode in_char_value | in
//  out     | out_valid out_stall out_matched           | out
//          | out_pattern_overflow                    |
//
// a new request is taken each cycle while in_stall is low; the position set
// update (cell chain plus one carry-style star closure) is combinational, registered in pre_r
// an end-of-text result is registered in the output register, or in the skid entry
// reset leaves an empty pattern with only position zero active, no clearing pass
// in_stall rises only when both the output register and the skid stage hold results
module wildcard_glob_matcher_unit #(
  parameter int MAX_PATTERN = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_opcode,
  input  logic [7:0] in_char_value,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_matched,
  output logic       out_pattern_overflow
);

  localparam int NPOS  = MAX_PATTERN + 1;
  localparam int LEN_W = $clog2(MAX_PATTERN + 1);

  wgm_pkg::opcode_t   op;
  logic               in_acc;

  logic [LEN_W-1:0]   len_r, len_nxt;
  logic               ovf_r, ovf_nxt;
  logic [NPOS-1:0]    pre_r, pre_nxt;
  logic [NPOS-1:0]    seed_set;
  logic [NPOS-1:0]    prop;
  logic [NPOS-1:0]    closed;
  logic [NPOS-1:0]    step_set;
  logic               clear_req;
  logic               append_req;

  wgm_pkg::cell_out_t cell_out [MAX_PATTERN];

  logic               res_valid;
  logic               res_match;
  logic               res_ovf;

  logic               out_valid_r, out_valid_nxt;
  logic               out_matched_r, out_ovf_r;
  logic               out_load;
  logic               skid_valid_r, skid_valid_nxt;
  logic               skid_matched_r, skid_ovf_r;
  logic               skid_load;

  assign op         = wgm_pkg::opcode_t'(in_opcode);
  assign in_stall   = skid_valid_r;
  assign in_acc     = in_valid && !in_stall;
  assign clear_req  = in_acc && (op == wgm_pkg::OP_CLEAR);
  assign append_req = in_acc && (op == wgm_pkg::OP_APPEND);
  assign seed_set   = {{(NPOS-1){1'b0}}, 1'b1};

  // cell chain
  genvar g;
  generate
    for (g = 0; g < MAX_PATTERN; g++) begin : g_cell
      wgm_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (clear_req),
        .load      (append_req && (len_r == LEN_W'(g))),
        .load_char (in_char_value),
        .active    (closed[g]),
        .text_char (in_char_value),
        .cell_out  (cell_out[g])
      );
      assign prop[g+1] = cell_out[g].star;
      if (g == 0) begin : g_first
        assign step_set[g] = cell_out[g].stay;
      end else begin : g_rest
        assign step_set[g] = cell_out[g].stay | cell_out[g-1].adv;
      end
    end
  endgenerate

  assign prop[0]              = 1'b0;
  assign step_set[NPOS-1]     = cell_out[MAX_PATTERN-1].adv;

  wgm_closure #(
    .WIDTH (NPOS)
  ) u_closure (
    .seeds  (pre_r),
    .prop   (prop),
    .closed (closed)
  );

  assign res_match = closed[len_r] && !ovf_r;
  assign res_ovf   = ovf_r;

  always_comb begin
    pre_nxt   = pre_r;
    len_nxt   = len_r;
    ovf_nxt   = ovf_r;
    res_valid = 1'b0;
    if (in_acc) begin
      unique case (op)
        wgm_pkg::OP_CLEAR: begin
          len_nxt = '0;
          ovf_nxt = 1'b0;
          pre_nxt = seed_set;
        end
        wgm_pkg::OP_APPEND: begin
          if (len_r != LEN_W'(MAX_PATTERN)) begin
            len_nxt = len_r + LEN_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          pre_nxt = seed_set;
        end
        wgm_pkg::OP_TEXT: begin
          pre_nxt = step_set;
        end
        wgm_pkg::OP_END: begin
          res_valid = 1'b1;
          pre_nxt   = seed_set;
        end
        default: begin
          pre_nxt = pre_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
      ovf_r <= 1'b0;
      pre_r <= seed_set;
    end else begin
      len_r <= len_nxt;
      ovf_r <= ovf_nxt;
      pre_r <= pre_nxt;
    end
  end

  // output register with one skid entry behind it
  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_load       = 1'b0;
    skid_load      = 1'b0;
    if (!out_valid_r || !out_stall) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = res_valid;
        out_load      = res_valid;
      end
    end else if (res_valid) begin
      skid_valid_nxt = 1'b1;
      skid_load      = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_matched_r <= res_match;
      out_ovf_r     <= res_ovf;
    end else if ((!out_valid_r || !out_stall) && skid_valid_r) begin
      out_matched_r <= skid_matched_r;
      out_ovf_r     <= skid_ovf_r;
    end
    if (skid_load) begin
      skid_matched_r <= res_match;
      skid_ovf_r     <= res_ovf;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_matched          = out_matched_r;
  assign out_pattern_overflow = out_ovf_r;

  // skid entry only fills behind a held result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry valid without output register valid");

  // overflow only once the store is full
  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> (len_r == LEN_W'(MAX_PATTERN)))
    else $error("overflow flag set with free pattern entries");

  // an overflowed pattern never reports a match
  a_ovf_no_match: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ovf_r) |-> !out_matched_r)
    else $error("match reported with pattern overflow");

  // a clear always leaves an empty, non-overflowed pattern
  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    clear_req |=> ((len_r == '0) && !ovf_r))
    else $error("clear request did not empty the pattern");

endmodule
